// ===== design/erm_pkg.sv =====
// erm_pkg: shared constants, codes and types for the engine RPM meter.
// Used by the channel interfaces, controller, datapath and top level.
// No dependencies.
package erm_pkg;

  // Averaging ring
  localparam int AVG_DEPTH = 25;
  localparam int IDX_W     = $clog2(AVG_DEPTH);

  // Field widths
  localparam int MODE_W    = 2;
  localparam int PERIOD_W  = 32;
  localparam int RPM_W     = 16;
  localparam int FREQ_W    = 28;
  localparam int CLK_W     = 28;
  localparam int PRESC_W   = 16;
  localparam int HYST_W    = 16;
  localparam int TIMEOUT_W = 16;
  localparam int TREND_W   = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  // RPM conversion and saturation
  localparam int RPM_MAX      = 65535;
  localparam int RPM_PER_HZ   = 60;
  localparam int RPM_SAT_FREQ = RPM_MAX / RPM_PER_HZ;
  localparam int SAT_W        = $clog2(RPM_SAT_FREQ + 1);
  localparam int SUM_W        = $clog2(AVG_DEPTH * RPM_MAX + 1);

  // Ring average by reciprocal multiply: (sum * ceil(2^s / depth)) >> s,
  // exact for every ring sum since 2^s >= depth * 2^SUM_W
  localparam int AVG_SHIFT  = SUM_W + IDX_W;
  localparam int AVG_RECIP  = (2**AVG_SHIFT + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int RECIP_W    = $clog2(AVG_RECIP + 1);
  localparam int AVG_PROD_W = SUM_W + RECIP_W;

  // Shared serial divider
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = 6;

  // Item mode codes
  localparam logic [MODE_W-1:0] MODE_CAPTURE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TREND   = 2'd2;

  // Trend codes
  localparam logic [TREND_W-1:0] TREND_CONST = 2'd0;
  localparam logic [TREND_W-1:0] TREND_UP    = 2'd1;
  localparam logic [TREND_W-1:0] TREND_DOWN  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd3;

  // Configuration reset values
  localparam logic [CLK_W-1:0]     CLOCK_RESET   = CLK_W'(72000000);
  localparam logic [PRESC_W-1:0]   PRESC_RESET   = '0;
  localparam logic [HYST_W-1:0]    HYST_RESET    = HYST_W'(250);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCALE,
    ST_FREQ,
    ST_PUSH,
    ST_AVG,
    ST_DONE
  } state_t;

  // Divider operand select
  typedef enum logic [1:0] {
    DIV_SCALE,
    DIV_FREQ
  } div_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_sel_t div_sel;
    logic     push;
    logic     tick;
    logic     trend;
    logic     avg_load;
    logic     emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              period_zero;
    logic              div_busy;
    logic              out_free;
  } status_t;

endpackage

// ===== design/erm_in_if.sv =====
// erm_in_if: input item channel (valid/ready plus mode and captured period).
// Depends on erm_pkg.
interface erm_in_if;
  logic                          valid;
  logic                          ready;
  logic [erm_pkg::MODE_W-1:0]    mode;
  logic [erm_pkg::PERIOD_W-1:0]  capture_period;

  modport source (output valid, mode, capture_period, input ready);
  modport sink   (input valid, mode, capture_period, output ready);
endinterface

// ===== design/erm_out_if.sv =====
// erm_out_if: result item channel (valid/ready plus the reported fields).
// Depends on erm_pkg.
interface erm_out_if;
  logic                         valid;
  logic                         ready;
  logic [erm_pkg::RPM_W-1:0]    average_rpm;
  logic [erm_pkg::FREQ_W-1:0]   frequency_hz;
  logic                         engine_running;
  logic [erm_pkg::TREND_W-1:0]  rpm_trend;

  modport source (output valid, average_rpm, frequency_hz, engine_running, rpm_trend,
                  input ready);
  modport sink   (input valid, average_rpm, frequency_hz, engine_running, rpm_trend,
                  output ready);
endinterface

// ===== design/erm_ctrl.sv =====
// erm_ctrl: sequencing state machine for the engine RPM meter.
// Depends on erm_pkg; drives the datapath through cmd_t, reads status_t.
module erm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  erm_pkg::status_t status,
  output erm_pkg::cmd_t    cmd
);

  erm_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= erm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.div_sel   = erm_pkg::DIV_SCALE;
    in_ready      = 1'b0;
    unique case (state)
      erm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = erm_pkg::ST_DECODE;
        end
      end
      erm_pkg::ST_DECODE: begin
        case (status.mode)
          erm_pkg::MODE_CAPTURE: begin
            if (status.period_zero) begin
              state_next = erm_pkg::ST_PUSH;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = erm_pkg::DIV_SCALE;
              state_next    = erm_pkg::ST_SCALE;
            end
          end
          erm_pkg::MODE_TICK: begin
            cmd.tick   = 1'b1;
            state_next = erm_pkg::ST_DONE;
          end
          erm_pkg::MODE_TREND: begin
            cmd.trend  = 1'b1;
            state_next = erm_pkg::ST_DONE;
          end
          default: begin
            state_next = erm_pkg::ST_DONE;
          end
        endcase
      end
      // clock / (prescaler + 1)
      erm_pkg::ST_SCALE: begin
        if (!status.div_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = erm_pkg::DIV_FREQ;
          state_next    = erm_pkg::ST_FREQ;
        end
      end
      // scaled clock / period
      erm_pkg::ST_FREQ: begin
        if (!status.div_busy) begin
          state_next = erm_pkg::ST_PUSH;
        end
      end
      erm_pkg::ST_PUSH: begin
        cmd.push   = 1'b1;
        state_next = erm_pkg::ST_AVG;
      end
      // ring sum / depth by reciprocal multiply
      erm_pkg::ST_AVG: begin
        cmd.avg_load = 1'b1;
        state_next   = erm_pkg::ST_DONE;
      end
      erm_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = erm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = erm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/erm_dp.sv =====
// erm_dp: datapath of the engine RPM meter: config registers, serial divider,
// averaging ring, running countdown, trend logic and result register.
// Depends on erm_pkg; driven by erm_ctrl.
module erm_dp (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [erm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [erm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input item payload
  input  logic [erm_pkg::MODE_W-1:0]       in_mode,
  input  logic [erm_pkg::PERIOD_W-1:0]     in_period,
  // result item
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [erm_pkg::RPM_W-1:0]        out_average_rpm,
  output logic [erm_pkg::FREQ_W-1:0]       out_frequency_hz,
  output logic                             out_engine_running,
  output logic [erm_pkg::TREND_W-1:0]      out_rpm_trend,
  // control
  input  erm_pkg::cmd_t                    cmd,
  output erm_pkg::status_t                 status
);

  // Configuration registers
  logic [erm_pkg::CLK_W-1:0]     core_clock_hz;
  logic [erm_pkg::PRESC_W-1:0]   timer_prescaler;
  logic [erm_pkg::HYST_W-1:0]    trend_hysteresis;
  logic [erm_pkg::TIMEOUT_W-1:0] running_timeout;

  // Latched item
  logic [erm_pkg::MODE_W-1:0]    item_mode;
  logic [erm_pkg::PERIOD_W-1:0]  item_period;

  // Meter state
  logic [erm_pkg::RPM_W-1:0]     ring [erm_pkg::AVG_DEPTH];
  logic [erm_pkg::IDX_W-1:0]     ring_write_index;
  logic [erm_pkg::SUM_W-1:0]     ring_sum;
  logic [erm_pkg::RPM_W-1:0]     average_rpm;
  logic [erm_pkg::FREQ_W-1:0]    last_frequency;
  logic [erm_pkg::TIMEOUT_W-1:0] timeout_countdown;
  logic                          running_flag;
  logic [erm_pkg::RPM_W-1:0]     reference_rpm;
  logic [erm_pkg::TREND_W-1:0]   trend_code;

  // Divider registers
  logic [erm_pkg::DIV_W-1:0]     div_rem;
  logic [erm_pkg::DIV_W-1:0]     div_quo;
  logic [erm_pkg::DIV_W-1:0]     div_den;
  logic [erm_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [erm_pkg::DIV_W:0]       div_shift;
  logic [erm_pkg::DIV_W:0]       div_trial;
  logic [erm_pkg::DIV_W-1:0]     div_dividend;
  logic [erm_pkg::DIV_W-1:0]     div_divisor;
  logic [erm_pkg::DIV_CNT_W-1:0] div_steps;

  logic [erm_pkg::FREQ_W-1:0]    freq_new;
  logic [erm_pkg::RPM_W-1:0]     rpm_new;
  logic [erm_pkg::SUM_W-1:0]     sum_next;
  logic [erm_pkg::IDX_W-1:0]     index_next;
  logic [erm_pkg::AVG_PROD_W-1:0] avg_prod;

  logic signed [erm_pkg::RPM_W+1:0] diff_up;
  logic signed [erm_pkg::RPM_W+1:0] diff_down;
  logic signed [erm_pkg::RPM_W+1:0] hyst_s;

  // Status
  assign status.mode        = item_mode;
  assign status.period_zero = (item_period == '0);
  assign status.div_busy    = (div_cnt != '0);
  assign status.out_free    = !out_valid || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      core_clock_hz    <= erm_pkg::CLOCK_RESET;
      timer_prescaler  <= erm_pkg::PRESC_RESET;
      trend_hysteresis <= erm_pkg::HYST_RESET;
      running_timeout  <= erm_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        erm_pkg::CFG_CORE_CLOCK: core_clock_hz    <= cfg_data[erm_pkg::CLK_W-1:0];
        erm_pkg::CFG_PRESCALER:  timer_prescaler  <= cfg_data[erm_pkg::PRESC_W-1:0];
        erm_pkg::CFG_HYSTERESIS: trend_hysteresis <= cfg_data[erm_pkg::HYST_W-1:0];
        erm_pkg::CFG_TIMEOUT:    running_timeout  <= cfg_data[erm_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode   <= in_mode;
      item_period <= in_period;
    end
  end

  // Divider operand select
  always_comb begin
    case (cmd.div_sel)
      erm_pkg::DIV_SCALE: begin
        div_dividend = {core_clock_hz, {(erm_pkg::DIV_W - erm_pkg::CLK_W){1'b0}}};
        div_divisor  = erm_pkg::DIV_W'({1'b0, timer_prescaler}) + erm_pkg::DIV_W'(1);
        div_steps    = erm_pkg::DIV_CNT_W'(erm_pkg::CLK_W);
      end
      erm_pkg::DIV_FREQ: begin
        div_dividend = {div_quo[erm_pkg::FREQ_W-1:0],
                        {(erm_pkg::DIV_W - erm_pkg::FREQ_W){1'b0}}};
        div_divisor  = item_period;
        div_steps    = erm_pkg::DIV_CNT_W'(erm_pkg::FREQ_W);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = erm_pkg::DIV_W'(1);
        div_steps    = '0;
      end
    endcase
  end

  // Restoring divider, one quotient bit per cycle; dividend is left-aligned in div_quo
  assign div_shift = {div_rem, div_quo[erm_pkg::DIV_W-1]};
  assign div_trial = div_shift - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_rem <= '0;
      div_quo <= div_dividend;
      div_den <= div_divisor;
      div_cnt <= div_steps;
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
      if (!div_trial[erm_pkg::DIV_W]) begin
        div_rem <= div_trial[erm_pkg::DIV_W-1:0];
        div_quo <= {div_quo[erm_pkg::DIV_W-2:0], 1'b1};
      end else begin
        div_rem <= div_shift[erm_pkg::DIV_W-1:0];
        div_quo <= {div_quo[erm_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  // Frequency to saturated RPM, ring update
  assign freq_new = status.period_zero ? '0 : div_quo[erm_pkg::FREQ_W-1:0];
  assign rpm_new  = (freq_new > erm_pkg::FREQ_W'(erm_pkg::RPM_SAT_FREQ))
                  ? erm_pkg::RPM_W'(erm_pkg::RPM_MAX)
                  : erm_pkg::RPM_W'(freq_new[erm_pkg::SAT_W-1:0]
                                    * erm_pkg::RPM_W'(erm_pkg::RPM_PER_HZ));
  assign sum_next = ring_sum - erm_pkg::SUM_W'(ring[ring_write_index])
                  + erm_pkg::SUM_W'(rpm_new);
  assign index_next = (ring_write_index == erm_pkg::IDX_W'(erm_pkg::AVG_DEPTH - 1))
                    ? '0 : ring_write_index + 1'b1;

  // Ring average: sum times the scaled reciprocal of the depth
  assign avg_prod = erm_pkg::AVG_PROD_W'(ring_sum)
                  * erm_pkg::AVG_PROD_W'(erm_pkg::AVG_RECIP);

  // Signed differences for the hysteresis compare
  assign diff_up   = $signed({2'b00, average_rpm}) - $signed({2'b00, reference_rpm});
  assign diff_down = $signed({2'b00, reference_rpm}) - $signed({2'b00, average_rpm});
  assign hyst_s    = $signed({2'b00, trend_hysteresis});

  // Meter state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < erm_pkg::AVG_DEPTH; i++) begin
        ring[i] <= '0;
      end
      ring_write_index  <= '0;
      ring_sum          <= '0;
      average_rpm       <= '0;
      last_frequency    <= '0;
      timeout_countdown <= '0;
      running_flag      <= 1'b0;
      reference_rpm     <= '0;
      trend_code        <= erm_pkg::TREND_CONST;
    end else begin
      // capture: store frequency and RPM, advance index, reload countdown
      if (cmd.push) begin
        last_frequency         <= freq_new;
        ring[ring_write_index] <= rpm_new;
        ring_sum               <= sum_next;
        ring_write_index       <= index_next;
        timeout_countdown      <= running_timeout;
      end
      if (cmd.avg_load) begin
        average_rpm <= avg_prod[erm_pkg::AVG_SHIFT +: erm_pkg::RPM_W];
      end
      // tick: count down, or stop and clear the ring
      if (cmd.tick) begin
        if (timeout_countdown != '0) begin
          timeout_countdown <= timeout_countdown - 1'b1;
          running_flag      <= 1'b1;
        end else begin
          running_flag <= 1'b0;
          for (int i = 0; i < erm_pkg::AVG_DEPTH; i++) begin
            ring[i] <= '0;
          end
          ring_sum    <= '0;
          average_rpm <= '0;
        end
      end
      // trend check with hysteresis
      if (cmd.trend) begin
        if (diff_up >= hyst_s) begin
          trend_code    <= erm_pkg::TREND_UP;
          reference_rpm <= average_rpm;
        end else if (diff_down >= hyst_s) begin
          trend_code    <= erm_pkg::TREND_DOWN;
          reference_rpm <= average_rpm;
        end else begin
          trend_code <= erm_pkg::TREND_CONST;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_average_rpm    <= average_rpm;
      out_frequency_hz   <= last_frequency;
      out_engine_running <= running_flag;
      out_rpm_trend      <= trend_code;
    end
  end

endmodule

// ===== design/engine_rpm_meter_core.sv =====
// engine_rpm_meter_core: top level, controller plus datapath.
// Depends on erm_pkg, erm_in_if, erm_out_if, erm_ctrl, erm_dp.
// Capture item: accept, decode, the two divisions on the shared serial divider
//   at one bit per cycle (28 + 28 steps), push, average, result; zero period
//   skips the divisions. Tick, trend check and unused mode: accept, decode, result.
// One item at a time; the input opens again in the cycle the result becomes
//   valid, and an item is accepted while a result waits.
// Reset (rst, synchronous) restores register defaults and clears ring and state.
module engine_rpm_meter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [erm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [erm_pkg::CFG_DATA_W-1:0]  cfg_data,
  erm_in_if.sink                          item_in,
  erm_out_if.source                       result_out
);

  erm_pkg::cmd_t    cmd;
  erm_pkg::status_t status;

  erm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  erm_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_mode            (item_in.mode),
    .in_period          (item_in.capture_period),
    .out_valid          (result_out.valid),
    .out_ready          (result_out.ready),
    .out_average_rpm    (result_out.average_rpm),
    .out_frequency_hz   (result_out.frequency_hz),
    .out_engine_running (result_out.engine_running),
    .out_rpm_trend      (result_out.rpm_trend),
    .cmd                (cmd),
    .status             (status)
  );

endmodule

// ===== design/erm_checker.sv =====
// erm_checker: port-level assertions for engine_rpm_meter_core, attached by bind.
// Depends on erm_pkg.
module erm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [erm_pkg::RPM_W-1:0]     average_rpm,
  input logic [erm_pkg::FREQ_W-1:0]    frequency_hz,
  input logic                          engine_running,
  input logic [erm_pkg::TREND_W-1:0]   rpm_trend
);

  // Reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("result pending or input closed after reset");

  // One item in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk)
    !rst && in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in progress");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk)
    !rst && out_valid && !out_ready |=>
      out_valid && $stable(average_rpm) && $stable(frequency_hz)
      && $stable(engine_running) && $stable(rpm_trend))
    else $error("stalled result changed");

  // Trend is never the unused code
  a_trend_code: assert property (@(posedge clk)
    out_valid |-> rpm_trend == erm_pkg::TREND_CONST || rpm_trend == erm_pkg::TREND_UP
               || rpm_trend == erm_pkg::TREND_DOWN)
    else $error("invalid trend code");

endmodule

bind engine_rpm_meter_core erm_checker u_erm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item_in.valid),
  .in_ready       (item_in.ready),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .average_rpm    (result_out.average_rpm),
  .frequency_hz   (result_out.frequency_hz),
  .engine_running (result_out.engine_running),
  .rpm_trend      (result_out.rpm_trend)
);

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for engine_rpm_meter_core (capture, tick, trend items).
// Depends on erm_pkg, erm_in_if, erm_out_if and the core; a scoreboard predicts each result.
// Directed corner items, then five randomized phases under different register settings.
`timescale 1ns / 100ps

module tb_top;
  import erm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [RPM_W-1:0]   average_rpm;
    logic [FREQ_W-1:0]  frequency_hz;
    logic               engine_running;
    logic [TREND_W-1:0] rpm_trend;
  } rpm_reading_t;

  // Tachometer model plus the queue of readings still owed by the core
  class rpm_scoreboard;
    logic [CLK_W-1:0]     core_clock;
    logic [PRESC_W-1:0]   prescaler;
    logic [HYST_W-1:0]    hysteresis;
    logic [TIMEOUT_W-1:0] timeout;
    logic [RPM_W-1:0]     ring [AVG_DEPTH];
    int unsigned          slot;
    int unsigned          ring_total;
    logic [FREQ_W-1:0]    last_hz;
    logic [TIMEOUT_W-1:0] countdown;
    logic                 running;
    logic [RPM_W-1:0]     ref_rpm;
    logic [TREND_W-1:0]   trend;
    rpm_reading_t         readings_due [$];
    int                   errors;

    function new();
      core_clock = CLOCK_RESET;
      prescaler  = PRESC_RESET;
      hysteresis = HYST_RESET;
      timeout    = TIMEOUT_RESET;
      foreach (ring[i]) ring[i] = '0;
      slot       = 0;
      ring_total = 0;
      last_hz    = '0;
      countdown  = '0;
      running    = 1'b0;
      ref_rpm    = '0;
      trend      = TREND_CONST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CORE_CLOCK: core_clock = data[CLK_W-1:0];
        CFG_PRESCALER:  prescaler  = data[PRESC_W-1:0];
        CFG_HYSTERESIS: hysteresis = data[HYST_W-1:0];
        CFG_TIMEOUT:    timeout    = data[TIMEOUT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    // Advance the model by one item and queue the reading it must produce
    function void take_item(logic [MODE_W-1:0] mode, logic [PERIOD_W-1:0] period);
      logic [31:0]  scaled;
      logic [31:0]  hz;
      longint       rpm;
      int           avg;
      rpm_reading_t r;
      case (mode)
        MODE_CAPTURE: begin
          hz  = '0;
          rpm = 0;
          if (period != 0) begin
            scaled = 32'(core_clock) / (32'(prescaler) + 32'd1);
            hz     = scaled / period;
            rpm    = longint'(hz) * 60;
            if (rpm > 65535) rpm = 65535;
          end
          last_hz          = hz[FREQ_W-1:0];
          ring_total       = ring_total - ring[slot] + int'(rpm);
          ring[slot]       = rpm[RPM_W-1:0];
          slot             = (slot + 1) % AVG_DEPTH;
          countdown        = timeout;
        end
        MODE_TICK: begin
          if (countdown != 0) begin
            countdown = countdown - 1'b1;
            running   = 1'b1;
          end else begin
            // engine stopped: the whole ring is flushed, the write slot is kept
            running = 1'b0;
            foreach (ring[i]) ring[i] = '0;
            ring_total = 0;
          end
        end
        MODE_TREND: begin
          avg = int'(ring_total / AVG_DEPTH);
          if (avg - int'(ref_rpm) >= int'(hysteresis)) begin
            trend   = TREND_UP;
            ref_rpm = avg[RPM_W-1:0];
          end else if (int'(ref_rpm) - avg >= int'(hysteresis)) begin
            trend   = TREND_DOWN;
            ref_rpm = avg[RPM_W-1:0];
          end else begin
            trend = TREND_CONST;
          end
        end
        default: ;
      endcase
      r.average_rpm    = RPM_W'(ring_total / AVG_DEPTH);
      r.frequency_hz   = last_hz;
      r.engine_running = running;
      r.rpm_trend      = trend;
      readings_due.push_back(r);
    endfunction

    function void match_reading(rpm_reading_t got);
      rpm_reading_t want;
      if (readings_due.size() == 0) begin
        $error("result item with no item outstanding");
        errors++;
        return;
      end
      want = readings_due.pop_front();
      if (got.average_rpm !== want.average_rpm) begin
        $error("average_rpm: expected %0d, actual %0d", want.average_rpm, got.average_rpm);
        errors++;
      end
      if (got.frequency_hz !== want.frequency_hz) begin
        $error("frequency_hz: expected %0d, actual %0d", want.frequency_hz, got.frequency_hz);
        errors++;
      end
      if (got.engine_running !== want.engine_running) begin
        $error("engine_running: expected %0d, actual %0d",
               want.engine_running, got.engine_running);
        errors++;
      end
      if (got.rpm_trend !== want.rpm_trend) begin
        $error("rpm_trend: expected %0d, actual %0d", want.rpm_trend, got.rpm_trend);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm = 1'b0;
  rpm_scoreboard         sb = new();

  erm_in_if  item_if ();
  erm_out_if result_if ();

  engine_rpm_meter_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (item_if),
    .result_out (result_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: random back-pressure except during the calm phase
  always @(posedge clk) begin
    result_if.ready <= calm || ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready)
      sb.match_reading('{result_if.average_rpm, result_if.frequency_hz,
                         result_if.engine_running, result_if.rpm_trend});
  end

  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one item, after a random gap unless calm; valid stays high on return
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [PERIOD_W-1:0] period);
    int gap;
    gap = 0;
    if (!calm)
      while (gap < 10 && $urandom_range(0, 99) < 32) gap++;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid          <= 1'b1;
    item_if.mode           <= mode;
    item_if.capture_period <= period;
    do @(posedge clk); while (!item_if.ready);
    sb.take_item(mode, period);
  endtask

  // Drop valid and wait for every owed reading
  task automatic drain();
    item_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] clock_hz, presc, hyst, tmo);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_CORE_CLOCK, CFG_PRESCALER, CFG_HYSTERESIS, CFG_TIMEOUT};
    val = '{clock_hz, presc, hyst, tmo};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Periods mostly near the useful RPM band for the current clock, plus extremes
  function automatic logic [PERIOD_W-1:0] pick_period();
    logic [31:0] scaled;
    int unsigned sel;
    scaled = 32'(sb.core_clock) / (32'(sb.prescaler) + 32'd1);
    sel = $urandom_range(0, 99);
    if (sel < 4) return '0;
    if (sel < 14 || scaled == 0) return $urandom;
    if (sel < 22) return $urandom_range(1, 64);
    return scaled / $urandom_range(1, 1150) + $urandom_range(0, 3);
  endfunction

  // One randomized phase: mostly ring fills and tick runs, some loose items
  task automatic random_phase(input int quota);
    int sent;
    int sel;
    int burst;
    sent = 0;
    while (sent < quota) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        burst = $urandom_range(2, 12);
        repeat (burst) send_item(MODE_TICK, $urandom);
        sent += burst;
      end else if (sel < 12) begin
        burst = $urandom_range(10, 30);
        repeat (burst) send_item(MODE_CAPTURE, pick_period());
        send_item(MODE_TREND, $urandom);
        sent += burst + 1;
      end else if (sel < 50) begin
        send_item(MODE_CAPTURE, pick_period());
        sent++;
      end else if (sel < 80) begin
        send_item(MODE_TICK, $urandom);
        sent++;
      end else if (sel < 97) begin
        send_item(MODE_TREND, $urandom);
        sent++;
      end else begin
        send_item(MODE_UNUSED, $urandom);
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_CORE_CLOCK;
    cfg_data               = '0;
    item_if.valid          = 1'b0;
    item_if.mode           = MODE_CAPTURE;
    item_if.capture_period = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: corners of the period, saturation edge, every mode
    send_item(MODE_TREND, '0);
    send_item(MODE_UNUSED, '1);
    send_item(MODE_TICK, '0);
    send_item(MODE_CAPTURE, '0);
    send_item(MODE_CAPTURE, 32'd1);
    send_item(MODE_CAPTURE, '1);
    send_item(MODE_CAPTURE, 32'd72000);
    send_item(MODE_CAPTURE, 32'd65934);
    send_item(MODE_CAPTURE, 32'd65873);
    send_item(MODE_TICK, '1);
    send_item(MODE_TREND, '0);
    send_item(MODE_CAPTURE, 32'd1200000);
    send_item(MODE_TREND, '1);
    send_item(MODE_TICK, '0);
    send_item(MODE_UNUSED, '0);
    drain();

    // Zero clock, zero hysteresis, zero timeout; prescaler write wider than the register
    load_settings('0, '1, '0, '0);
    send_item(MODE_CAPTURE, 32'd1000);
    send_item(MODE_TICK, '0);
    send_item(MODE_TREND, '0);
    send_item(MODE_TREND, '0);
    send_item(MODE_TICK, '0);
    drain();

    // Widest clock, largest hysteresis, shortest nonzero timeout
    load_settings('1, '0, 28'hFFFF, 28'd1);
    send_item(MODE_CAPTURE, 32'd1);
    send_item(MODE_TICK, '0);
    send_item(MODE_TICK, '0);
    send_item(MODE_TREND, '0);
    drain();

    // Randomized phases
    load_settings(28'd72000000, 28'd0, 28'd250, 28'd1000);
    random_phase(140);

    calm = 1'b1;
    load_settings(28'd16000000, 28'd15, 28'($urandom_range(0, 500)), 28'd8);
    random_phase(140);
    calm = 1'b0;

    load_settings(28'hFFFFFFF, 28'hFFFFFFF, 28'hFFFF, 28'hFFFF);
    random_phase(140);

    load_settings(28'($urandom_range(1, 200000000)), 28'($urandom_range(0, 255)),
                  28'($urandom_range(0, 2000)), 28'($urandom_range(1, 40)));
    random_phase(140);

    load_settings(28'd200000000, 28'd1, 28'd1, 28'd1);
    random_phase(140);

    // let any stray result show up before the verdict
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
